// ===== rtl/core/spi_register_access_master_macros.svh =====
// Assertion macros shared by the SPI register access master.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef SPI_REGISTER_ACCESS_MASTER_MACROS_SVH
`define SPI_REGISTER_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srm: next-cycle check failed");

`endif

// ===== rtl/core/srm_pkg.sv =====
// Types and constants for the SPI register access master.
// No dependencies; imported by the interfaces and every module.
package srm_pkg;

	localparam logic       ACTION_READ      = 1'b0;
	localparam logic       ACTION_WRITE     = 1'b1;
	localparam logic [11:0] SHORT_ADDR_LIMIT = 12'h070;
	localparam logic [3:0] LONG_WR_NIBBLE   = 4'hF;
	localparam logic [3:0] LONG_RD_NIBBLE   = 4'h7;
	localparam logic [1:0] SHORT_FRAME_LEN  = 2'd2;
	localparam logic [1:0] LONG_FRAME_LEN   = 2'd3;
	localparam logic [2:0] LAST_BIT         = 3'd7;
	localparam logic [7:0] TICK_MAX         = 8'd255;
	localparam logic [7:0] HP_RESET         = 8'd1;

	// One tick of the serial engine
	typedef struct packed {
		logic        start_req;
		logic        action;
		logic [11:0] address;
		logic [7:0]  write_data;
		logic        miso;
	} srm_item_t;

	// Pin levels and status after the tick
	typedef struct packed {
		logic       chip_select_n;
		logic       serial_clock;
		logic       mosi;
		logic       busy_res;
		logic       read_valid;
		logic [7:0] read_data;
	} srm_result_t;

	// Engine status seen by the top level
	typedef struct packed {
		logic busy;
	} srm_status_t;

endpackage

// ===== rtl/core/srm_ifs.sv =====
// Valid/ready channel interfaces for ticks in and results out.
// Depends on srm_pkg for the payload types.
interface srm_item_if import srm_pkg::*; ();
	logic      valid;
	logic      ready;
	srm_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface srm_result_if import srm_pkg::*; ();
	logic        valid;
	logic        ready;
	srm_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/spi_register_access_master.sv =====
// SPI mode-0 register access master: one transfer in gives one result out.
// The result for a tick is registered in the output stage when the tick is accepted.
// Throughput: one tick per cycle, limited only by the single result register.
// Reset (arst_n low, asynchronous): engine idle, chip select high, half period 1.
// Depends on srm_pkg, srm_ifs, srm_engine, srm_out_stage and the macros header.
`include "spi_register_access_master_macros.svh"
module spi_register_access_master import srm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	srm_item_if.sink    cmd,
	srm_result_if.source res
);

	logic [7:0]  half_period_q;
	logic        space;
	logic        accept;
	srm_result_t result;
	srm_status_t status;

	// Serial clock half period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HP_RESET;
		end else if (cfg_we) begin
			half_period_q <= cfg_wdata;
		end
	end

	assign cmd.ready = space;
	assign accept    = cmd.valid && space;

	srm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_period (half_period_q),
		.advance     (accept),
		.item        (cmd.payload),
		.result      (result),
		.status      (status)
	);

	srm_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.result (result),
		.space  (space),
		.res    (res)
	);

	// A completed read is reported only with the frame closed
	`SRM_ASSERT_NOW(a_read_done_idle, res.valid && res.payload.read_valid, !res.payload.busy_res && res.payload.chip_select_n)
	// Idle ticks keep the bus quiet
	`SRM_ASSERT_NOW(a_idle_quiet, res.valid && !res.payload.busy_res, !res.payload.serial_clock && !res.payload.mosi)
	// A start taken while idle opens a frame in the next result
	`SRM_ASSERT_NEXT(a_start_opens, accept && !status.busy && cmd.payload.start_req, res.valid && !res.payload.chip_select_n && res.payload.busy_res)

endmodule

// ===== rtl/core/srm_engine.sv =====
// Serial engine state and the single-tick update of the SPI master.
// Depends on srm_pkg; state advances once per accepted transfer.
module srm_engine import srm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  half_period,
	input  logic        advance,
	input  srm_item_t   item,
	output srm_result_t result,
	output srm_status_t status
);

	logic        busy_q,    busy_d;
	logic [7:0]  tick_q,    tick_d;
	logic        sck_q,     sck_d;
	logic [2:0]  bit_q,     bit_d;
	logic [1:0]  byte_q,    byte_d;
	logic [23:0] frame_q,   frame_d;
	logic [1:0]  len_q,     len_d;
	logic [7:0]  rx_q,      rx_d;
	logic        is_read_q, is_read_d;

	logic [7:0]  hp;
	logic [7:0]  tick_inc;
	logic [15:0] long_hdr;
	logic [7:0]  data_byte;
	logic [7:0]  cur_byte;
	logic        done_valid;
	logic [7:0]  done_data;

	assign hp = (half_period == '0) ? 8'd1 : half_period;

	// Next state for one tick
	always_comb begin
		busy_d     = busy_q;
		tick_d     = tick_q;
		sck_d      = sck_q;
		bit_d      = bit_q;
		byte_d     = byte_q;
		frame_d    = frame_q;
		len_d      = len_q;
		rx_d       = rx_q;
		is_read_d  = is_read_q;
		done_valid = 1'b0;
		done_data  = '0;
		tick_inc   = (tick_q < TICK_MAX) ? tick_q + 8'd1 : tick_q;
		data_byte  = (item.action == ACTION_WRITE) ? item.write_data : 8'h00;
		long_hdr   = {(item.action == ACTION_WRITE) ? LONG_WR_NIBBLE : LONG_RD_NIBBLE,
			item.address};
		if (!busy_q) begin
			if (item.start_req) begin
				if (item.address < SHORT_ADDR_LIMIT) begin
					frame_d = {item.action, item.address[6:0], data_byte, 8'h00};
					len_d   = SHORT_FRAME_LEN;
				end else begin
					frame_d = {long_hdr, data_byte};
					len_d   = LONG_FRAME_LEN;
				end
				is_read_d = (item.action == ACTION_READ);
				busy_d    = 1'b1;
				tick_d    = '0;
				sck_d     = 1'b0;
				bit_d     = '0;
				byte_d    = '0;
				rx_d      = '0;
			end
		end else begin
			tick_d = tick_inc;
			if (tick_inc >= hp) begin
				tick_d = '0;
				if (!sck_q) begin
					// rising edge: sample MISO
					sck_d = 1'b1;
					rx_d  = {rx_q[6:0], item.miso};
				end else begin
					// falling edge: next bit, maybe end of frame
					sck_d = 1'b0;
					if (bit_q >= LAST_BIT) begin
						bit_d  = '0;
						byte_d = byte_q + 2'd1;
						if (byte_d >= len_q) begin
							busy_d = 1'b0;
							if (is_read_q) begin
								done_valid = 1'b1;
								done_data  = rx_q;
							end
						end
					end else begin
						bit_d = bit_q + 3'd1;
					end
				end
			end
		end
	end

	// Byte on the wire after the update
	always_comb begin
		case (byte_d)
			2'd0:    cur_byte = frame_d[23:16];
			2'd1:    cur_byte = frame_d[15:8];
			2'd2:    cur_byte = frame_d[7:0];
			default: cur_byte = 8'h00;
		endcase
	end

	always_comb begin
		result.chip_select_n = !busy_d;
		result.serial_clock  = busy_d && sck_d;
		result.mosi          = busy_d && cur_byte[LAST_BIT - bit_d];
		result.busy_res      = busy_d;
		result.read_valid    = done_valid;
		result.read_data     = done_data;
	end

	assign status.busy = busy_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			tick_q    <= '0;
			sck_q     <= 1'b0;
			bit_q     <= '0;
			byte_q    <= '0;
			len_q     <= '0;
			is_read_q <= 1'b0;
		end else if (advance) begin
			busy_q    <= busy_d;
			tick_q    <= tick_d;
			sck_q     <= sck_d;
			bit_q     <= bit_d;
			byte_q    <= byte_d;
			len_q     <= len_d;
			is_read_q <= is_read_d;
		end
	end

	// Frame and receive shifter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			rx_q    <= '0;
		end else if (advance) begin
			frame_q <= frame_d;
			rx_q    <= rx_d;
		end
	end

endmodule

// ===== rtl/core/srm_out_stage.sv =====
// Result register between the engine and the output channel.
// Depends on srm_pkg and srm_result_if.
module srm_out_stage import srm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  srm_result_t   result,
	output logic          space,
	srm_result_if.source  res
);

	logic        valid_q;
	srm_result_t data_q;

	// Room for a new result when empty or being drained this cycle
	assign space = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign res.valid   = valid_q;
	assign res.payload = data_q;

endmodule
